@@ hdl/vector_angle_and_direction_top_defines.svh @@
// Assertion macros shared by the vector angle block.
`ifndef VECTOR_ANGLE_AND_DIRECTION_TOP_DEFINES_SVH
`define VECTOR_ANGLE_AND_DIRECTION_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define VAD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VAD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VAD_ASSERT(lbl, clk, rst, prop, msg)
`define VAD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ hdl/vad_pkg.sv @@
package vad_pkg;

   localparam int DIV_BITS    = 15;
   localparam int RSP_LATENCY = DIV_BITS + 4;

   typedef struct packed {
      logic signed [15:0] dx;
      logic signed [15:0] dy;
   } vad_req_type;

   typedef struct packed {
      logic [15:0]        angle;
      logic signed [15:0] cosine;
      logic signed [15:0] sine;
      logic               zero_vector;
   } vad_rsp_type;

   // side information that rides along with the quotient
   typedef struct packed {
      logic       zero;
      logic       force_max;
      logic       diag;
      logic       neg;
      logic [1:0] base;
   } vad_tag_type;

   localparam logic [15:0]         OCT_DIAG        = 16'hE000;
   localparam logic [15:0]         ANGLE_MAX       = 16'hFFFF;
   localparam logic [DIV_BITS-1:0] ATAN_TWO_STEP   = 15'd27369;
   localparam logic [DIV_BITS-1:0] ATAN_THREE_STEP = 15'd4467;
   localparam logic [13:0]         SIN_TWO_STEP    = 14'd8057;
   localparam logic [13:0]         SIN_THREE_STEP  = 14'd5263;
   localparam logic [7:0]          TRIG_LAST       = 8'd128;
   localparam logic [15:0]         SAT_MAX         = 16'h7FFF;
   localparam logic [15:0]         COS_BIAS        = 16'h8000;

   localparam logic [13:0] COS_STEPS [0:8] = '{
      14'd415, 14'd1248, 14'd2088, 14'd2944, 14'd3819,
      14'd4725, 14'd5670, 14'd6670, 14'd7748};

   localparam logic [15:0] ATAN_TAB [0:127] = '{
      16'h0000,16'h028c,16'h0518,16'h07a3,16'h0a2f,16'h0cba,16'h0f45,16'h11cf,
      16'h1458,16'h16e1,16'h196a,16'h1bf1,16'h1e78,16'h20fe,16'h2382,16'h2606,
      16'h2889,16'h2b0a,16'h2d8a,16'h3008,16'h3285,16'h3501,16'h377b,16'h39f3,
      16'h3c6a,16'h3edf,16'h4152,16'h43c3,16'h4632,16'h489f,16'h4b0a,16'h4d73,
      16'h4fda,16'h523e,16'h54a0,16'h5700,16'h595d,16'h5bb8,16'h5e11,16'h6066,
      16'h62ba,16'h650a,16'h6758,16'h69a3,16'h6bec,16'h6e31,16'h7074,16'h72b4,
      16'h74f1,16'h772b,16'h7962,16'h7b96,16'h7dc7,16'h7ff5,16'h8220,16'h8448,
      16'h866d,16'h888e,16'h8aad,16'h8cc8,16'h8ee0,16'h90f5,16'h9307,16'h9515,
      16'h9720,16'h9928,16'h9b2d,16'h9d2e,16'h9f2c,16'ha127,16'ha31e,16'ha512,
      16'ha703,16'ha8f1,16'haadb,16'hacc2,16'haea6,16'hb086,16'hb263,16'hb43d,
      16'hb613,16'hb7e6,16'hb9b6,16'hbb83,16'hbd4c,16'hbf12,16'hc0d5,16'hc294,
      16'hc451,16'hc60a,16'hc7c0,16'hc972,16'hcb22,16'hccce,16'hce77,16'hd01d,
      16'hd1c0,16'hd35f,16'hd4fc,16'hd695,16'hd82c,16'hd9bf,16'hdb4f,16'hdcdc,
      16'hde67,16'hdfee,16'he172,16'he2f3,16'he471,16'he5ed,16'he765,16'he8db,
      16'hea4d,16'hebbd,16'hed2a,16'hee94,16'heffc,16'hf160,16'hf2c2,16'hf421,
      16'hf57d,16'hf6d7,16'hf82e,16'hf982,16'hfad4,16'hfc23,16'hfd6f,16'hfeb9};

   // 4*(1-cos) in Q15, one octant in steps of 64
   localparam logic [15:0] TRIG_C [0:128] = '{
      16'h0000,16'h0002,16'h000a,16'h0016,16'h0027,16'h003e,16'h0059,16'h0079,
      16'h009e,16'h00c8,16'h00f7,16'h012a,16'h0163,16'h01a1,16'h01e3,16'h022b,
      16'h0277,16'h02c8,16'h031f,16'h037a,16'h03da,16'h043f,16'h04a8,16'h0517,
      16'h058b,16'h0603,16'h0680,16'h0703,16'h078a,16'h0816,16'h08a6,16'h093c,
      16'h09d7,16'h0a76,16'h0b1a,16'h0bc3,16'h0c71,16'h0d23,16'h0ddb,16'h0e97,
      16'h0f58,16'h101e,16'h10e8,16'h11b8,16'h128c,16'h1365,16'h1442,16'h1525,
      16'h160c,16'h16f8,16'h17e8,16'h18de,16'h19d7,16'h1ad6,16'h1bd9,16'h1ce1,
      16'h1dee,16'h1eff,16'h2015,16'h2130,16'h224f,16'h2373,16'h249b,16'h25c8,
      16'h26f9,16'h282f,16'h296a,16'h2aa9,16'h2bed,16'h2d35,16'h2e82,16'h2fd3,
      16'h3128,16'h3282,16'h33e1,16'h3544,16'h36ab,16'h3817,16'h3987,16'h3afc,
      16'h3c75,16'h3df2,16'h3f74,16'h40fa,16'h4284,16'h4413,16'h45a5,16'h473c,
      16'h48d8,16'h4a77,16'h4c1b,16'h4dc3,16'h4f6f,16'h5120,16'h52d4,16'h548d,
      16'h564a,16'h580a,16'h59cf,16'h5b98,16'h5d66,16'h5f37,16'h610c,16'h62e5,
      16'h64c2,16'h66a3,16'h6888,16'h6a71,16'h6c5e,16'h6e4f,16'h7043,16'h723c,
      16'h7438,16'h7638,16'h783c,16'h7a44,16'h7c4f,16'h7e5e,16'h8071,16'h8288,
      16'h84a2,16'h86c0,16'h88e2,16'h8b07,16'h8d2f,16'h8f5c,16'h918c,16'h93bf,
      16'h95f6};

   // 2*sin in Q15
   localparam logic [15:0] TRIG_S [0:128] = '{
      16'h0000,16'h0192,16'h0324,16'h04b6,16'h0648,16'h07da,16'h096c,16'h0afe,
      16'h0c90,16'h0e21,16'h0fb3,16'h1144,16'h12d5,16'h1466,16'h15f7,16'h1787,
      16'h1918,16'h1aa8,16'h1c38,16'h1dc7,16'h1f56,16'h20e5,16'h2274,16'h2402,
      16'h2590,16'h271e,16'h28ab,16'h2a38,16'h2bc4,16'h2d50,16'h2edc,16'h3067,
      16'h31f1,16'h337c,16'h3505,16'h368e,16'h3817,16'h399f,16'h3b27,16'h3cae,
      16'h3e34,16'h3fba,16'h413f,16'h42c3,16'h4447,16'h45cb,16'h474d,16'h48cf,
      16'h4a50,16'h4bd1,16'h4d50,16'h4ecf,16'h504d,16'h51cb,16'h5348,16'h54c3,
      16'h563e,16'h57b9,16'h5932,16'h5aaa,16'h5c22,16'h5d99,16'h5f0f,16'h6084,
      16'h61f8,16'h636b,16'h64dd,16'h664e,16'h67be,16'h692d,16'h6a9b,16'h6c08,
      16'h6d74,16'h6edf,16'h7049,16'h71b2,16'h731a,16'h7480,16'h75e6,16'h774a,
      16'h78ad,16'h7a10,16'h7b70,16'h7cd0,16'h7e2f,16'h7f8c,16'h80e8,16'h8243,
      16'h839c,16'h84f5,16'h864c,16'h87a1,16'h88f6,16'h8a49,16'h8b9a,16'h8ceb,
      16'h8e3a,16'h8f88,16'h90d4,16'h921f,16'h9368,16'h94b0,16'h95f7,16'h973c,
      16'h9880,16'h99c2,16'h9b03,16'h9c42,16'h9d80,16'h9ebc,16'h9ff7,16'ha130,
      16'ha268,16'ha39e,16'ha4d2,16'ha605,16'ha736,16'ha866,16'ha994,16'haac1,
      16'habeb,16'had14,16'hae3c,16'haf62,16'hb086,16'hb1a8,16'hb2c9,16'hb3e8,
      16'hb505};

endpackage

@@ hdl/vector_angle_and_direction_top.sv @@
// Vector angle and direction: atan2 of a 16-bit vector plus Q15 cos/sin of that angle.
// Input: present req (dx, dy) with start high; the transaction is taken on a clock
// edge with start high and busy low. busy never rises, so a new vector can go in
// every cycle.
// Output: rsp_valid pulses for one cycle with rsp (angle, cosine, sine, zero_vector).
// Results leave in the order vectors were taken, one per vector.
// Stages: octant reduction (1), a 15-stage restoring divider with one quotient bit
// per stage (15), arctangent table and correction (1), sine/cosine table (1),
// quadrant folding and saturation (1). Throughput is one vector per cycle.
// Reset clears all stage valid bits; vectors in flight are dropped.
// The receiver has no way to stall the output; results must be taken as they appear.
module vector_angle_and_direction_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  vad_pkg::vad_req_type req,
   output logic                 rsp_valid,
   output vad_pkg::vad_rsp_type rsp
);
   import vad_pkg::*;
`include "vector_angle_and_direction_top_defines.svh"

   assign busy = 1'b0;

   // octant reduction
   logic signed [16:0] sx;
   logic signed [16:0] sy;
   logic signed [16:0] num;
   logic signed [16:0] den;
   logic [16:0]        num_mag;
   logic               found;
   vad_tag_type        tag_in;

   always_comb begin
      sx      = 17'(req.dx);
      sy      = 17'(req.dy);
      num     = '0;
      den     = 17'sd1;
      found   = 1'b1;
      tag_in  = '0;
      if (sx > 0 && -sx <= sy && sy < sx) begin
         num = sy;  den = sx;  tag_in.base = 2'd0;
      end else if (sy > 0 && -sy < sx && sx <= sy) begin
         num = -sx; den = sy;  tag_in.base = 2'd1;
      end else if (sx < 0 && sx < sy && sy <= -sx) begin
         num = -sy; den = -sx; tag_in.base = 2'd2;
      end else if (sy < 0 && sy <= sx && sx < -sy) begin
         num = sx;  den = -sy; tag_in.base = 2'd3;
      end else begin
         found = 1'b0;
      end
      num_mag          = num[16] ? 17'(-num) : 17'(num);
      tag_in.zero      = (req.dx == 16'sd0) && (req.dy == 16'sd0);
      tag_in.force_max = (req.dx == -16'sd32768) || (req.dy == -16'sd32768) || !found;
      tag_in.neg       = num[16];
      tag_in.diag      = num[16] && (num_mag[15:0] == den[15:0]);
   end

   logic                f_valid_ff;
   vad_tag_type         f_tag_ff;
   logic [15:0]         f_rem_ff;
   logic [DIV_BITS-1:0] f_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      f_tag_ff <= tag_in;
      f_rem_ff <= num_mag[15:0];
      f_den_ff <= den[DIV_BITS-1:0];
   end

   logic                d_valid;
   logic [DIV_BITS-1:0] d_quot;
   vad_tag_type         d_tag;

   vad_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid_ff),
      .in_rem    (f_rem_ff),
      .in_den    (f_den_ff),
      .in_tag    (f_tag_ff),
      .out_valid (d_valid),
      .out_quot  (d_quot),
      .out_tag   (d_tag)
   );

   // arctangent of the quotient with stepped slope correction
   logic [16:0] t_sum;
   logic [15:0] oct_off;
   logic [15:0] angle_in;

   always_comb begin
      t_sum = {1'b0, ATAN_TAB[d_quot[14:8]]} + 17'(d_quot[7:0]);
      if (d_quot <= ATAN_TWO_STEP) begin
         t_sum = t_sum + 17'(d_quot[7:0]);
         if (d_quot <= ATAN_THREE_STEP) begin
            t_sum = t_sum + 17'(d_quot[7:0]);
         end
      end
      oct_off = 16'(t_sum >> 3);
      if (d_tag.neg) begin
         oct_off = 16'(-oct_off);
      end
      if (d_tag.diag) begin
         oct_off = OCT_DIAG;
      end
      angle_in = oct_off + {d_tag.base, 14'b0};
      if (d_tag.force_max) begin
         angle_in = ANGLE_MAX;
      end
      if (d_tag.zero) begin
         angle_in = '0;
      end
   end

   logic        a_valid_ff;
   logic        a_zero_ff;
   logic [15:0] a_angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      a_zero_ff  <= d_tag.zero;
      a_angle_ff <= angle_in;
   end

   vad_trig u_trig (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid_ff),
      .in_angle  (a_angle_ff),
      .in_zero   (a_zero_ff),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   `VAD_ASSERT(a_zero_latency, clock, reset,
      (start && !busy && req.dx == 16'sd0 && req.dy == 16'sd0) |->
      ##RSP_LATENCY (rsp_valid && rsp.zero_vector), "zero vector result lost or late")
   `VAD_ASSERT(a_nonzero_latency, clock, reset,
      (start && !busy && (req.dx != 16'sd0 || req.dy != 16'sd0)) |->
      ##RSP_LATENCY (rsp_valid && !rsp.zero_vector), "result lost or late")
   `VAD_ASSERT(a_zero_fields, clock, reset,
      (rsp_valid && rsp.zero_vector) |->
      (rsp.angle == 16'h0000 && rsp.cosine == 16'sd0 && rsp.sine == 16'sd0),
      "zero vector result fields not cleared")
   `VAD_ASSERT_ALWAYS(a_reset_flush, clock, reset |=> !rsp_valid,
      "result strobe after reset")

endmodule

@@ hdl/vad_div.sv @@
module vad_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [15:0]                  in_rem,
   input  logic [vad_pkg::DIV_BITS-1:0] in_den,
   input  vad_pkg::vad_tag_type         in_tag,
   output logic                         out_valid,
   output logic [vad_pkg::DIV_BITS-1:0] out_quot,
   output vad_pkg::vad_tag_type         out_tag
);
   import vad_pkg::*;

   // one restoring step: {quotient bit, new remainder}
   function automatic logic [16:0] div_step(input logic [15:0] r,
                                            input logic [DIV_BITS-1:0] d);
      logic [16:0] trial;
      logic        fits;
      trial = {r, 1'b0};
      fits  = (trial >= {2'b00, d});
      return {fits, fits ? 16'(trial - {2'b00, d}) : trial[15:0]};
   endfunction

   // restoring divider, one quotient bit per stage; dividend low bits are zero
   logic                valid_ff [0:DIV_BITS-1];
   logic [15:0]         rem_ff   [0:DIV_BITS-1];
   logic [DIV_BITS-1:0] den_ff   [0:DIV_BITS-1];
   logic [DIV_BITS-1:0] quot_ff  [0:DIV_BITS-1];
   vad_tag_type         tag_ff   [0:DIV_BITS-1];
   logic [16:0]         step_res [0:DIV_BITS-1];

   always_comb begin
      step_res[0] = div_step(in_rem, in_den);
      for (int i = 1; i < DIV_BITS; i++) begin
         step_res[i] = div_step(rem_ff[i-1], den_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_BITS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < DIV_BITS; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= step_res[0][15:0];
      den_ff[0]  <= in_den;
      quot_ff[0] <= DIV_BITS'(step_res[0][16]);
      tag_ff[0]  <= in_tag;
      for (int i = 1; i < DIV_BITS; i++) begin
         rem_ff[i]  <= step_res[i][15:0];
         den_ff[i]  <= den_ff[i-1];
         quot_ff[i] <= {quot_ff[i-1][DIV_BITS-2:0], step_res[i][16]};
         tag_ff[i]  <= tag_ff[i-1];
      end
   end

   assign out_valid = valid_ff[DIV_BITS-1];
   assign out_quot  = quot_ff[DIV_BITS-1];
   assign out_tag   = tag_ff[DIV_BITS-1];

endmodule

@@ hdl/vad_trig.sv @@
module vad_trig (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [15:0]          in_angle,
   input  logic                 in_zero,
   output logic                 rsp_valid,
   output vad_pkg::vad_rsp_type rsp
);
   import vad_pkg::*;

   function automatic logic [15:0] neg_sat(input logic [15:0] v);
      logic [15:0] r;
      r = 16'(-v);
      return r[15] ? SAT_MAX : r;
   endfunction

   logic [13:0] ph;
   logic [7:0]  idx;
   logic [5:0]  rem6;
   logic [3:0]  steps;
   logic [16:0] c_sum;
   logic [16:0] s_sum;
   logic [15:0] cv_in;
   logic [15:0] sv_in;
   logic [2:0]  flag_in;

   always_comb begin
      ph    = in_angle[13] ? 14'(16'(-in_angle)) : in_angle[13:0];
      idx   = (ph[13:6] > TRIG_LAST) ? TRIG_LAST : ph[13:6];
      rem6  = ph[5:0];
      steps = '0;
      for (int i = 0; i < 9; i++) begin
         steps = steps + 4'(ph > COS_STEPS[i]);
      end
      c_sum = {1'b0, TRIG_C[idx]} + 17'(steps) * 17'(rem6);
      s_sum = {1'b0, TRIG_S[idx]} + 17'({rem6, 2'b00});
      if (ph <= SIN_TWO_STEP) begin
         s_sum = s_sum + 17'(rem6);
         if (ph <= SIN_THREE_STEP) begin
            s_sum = s_sum + 17'(rem6);
         end
      end
      cv_in   = 16'(c_sum >> 2) + COS_BIAS;
      sv_in   = 16'(-(16'(s_sum >> 1)));
      flag_in = {in_angle[15], in_angle[15] ^ in_angle[14], in_angle[14] ^ in_angle[13]};
   end

   logic        s1_valid_ff;
   logic        s1_zero_ff;
   logic [15:0] s1_angle_ff;
   logic [15:0] s1_cv_ff;
   logic [15:0] s1_sv_ff;
   logic [2:0]  s1_flag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_zero_ff  <= in_zero;
      s1_angle_ff <= in_angle;
      s1_cv_ff    <= cv_in;
      s1_sv_ff    <= sv_in;
      s1_flag_ff  <= flag_in;
   end

   // fold into the right quadrant: swap, then flip sign with saturation
   logic [15:0] cv_sw;
   logic [15:0] sv_sw;
   vad_rsp_type rsp_in;

   always_comb begin
      cv_sw = s1_flag_ff[0] ? s1_sv_ff : s1_cv_ff;
      sv_sw = s1_flag_ff[0] ? s1_cv_ff : s1_sv_ff;
      if (!s1_flag_ff[1]) begin
         cv_sw = neg_sat(cv_sw);
      end
      if (!s1_flag_ff[2]) begin
         sv_sw = neg_sat(sv_sw);
      end
      if (s1_zero_ff) begin
         rsp_in = '{angle: '0, cosine: '0, sine: '0, zero_vector: 1'b1};
      end else begin
         rsp_in = '{angle: s1_angle_ff, cosine: cv_sw, sine: sv_sw, zero_vector: 1'b0};
      end
   end

   logic        rsp_valid_ff;
   vad_rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ verif/vad_checker.sv @@
module vad_checker
   import vad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  vad_req_type req,
   input  logic        rsp_valid,
   input  vad_rsp_type rsp,
   output int          fail_count,
   output int          pending,
   output int          rsp_count
);
   timeunit 1ns;
   timeprecision 1ps;

   vad_rsp_type expected_rsps[$];

   function automatic logic [15:0] octant_offset(int q);
      logic [15:0] u, rem, t;
      logic is_neg;
      if (q == -32768) return OCT_DIAG;
      is_neg = q < 0;
      u = (is_neg ? -q : q) & 16'h7FFF;
      rem = u & 16'hFF;
      t = ATAN_TAB[u[14:8]] + rem;
      if (u <= 27369) begin
         t = t + rem;
         if (u <= 4467) t = t + rem;
      end
      t = t >> 3;
      if (is_neg) t = -t;
      return t;
   endfunction

   function automatic logic [15:0] negate_clip(logic [15:0] v);
      logic [15:0] r;
      r = -v;
      return r[15] ? SAT_MAX : r;
   endfunction

   function automatic vad_rsp_type predict_direction(vad_req_type r);
      vad_rsp_type o;
      int x, y, num, den, qi;
      longint q;
      logic [15:0] base, ang, flag, ph, rem, c, s, cv, sv, tmp;
      logic found;
      int idx;
      x = r.dx;
      y = r.dy;
      num = 0;
      den = 1;
      base = 0;
      found = 1;
      o = '0;
      if (x == 0 && y == 0) begin
         o.zero_vector = 1'b1;
         return o;
      end
      if (x == -32768 || y == -32768) begin
         ang = ANGLE_MAX;
      end else begin
         if (x > 0 && -x <= y && y < x) begin
            num = y; den = x; base = 16'h0000;
         end else if (y > 0 && -y < x && x <= y) begin
            num = -x; den = y; base = 16'h4000;
         end else if (x < 0 && x < y && y <= -x) begin
            num = -y; den = -x; base = 16'h8000;
         end else if (y < 0 && y <= x && x < -y) begin
            num = x; den = -y; base = 16'hC000;
         end else begin
            found = 0;
         end
         if (found && den > 0) begin
            q = (longint'(num) * 32768) / den;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            qi = int'(q);
            ang = octant_offset(qi) + base;
         end else begin
            ang = ANGLE_MAX;
         end
      end
      flag = ang ^ (ang >> 1);
      ph = ang[13] ? ((-ang) & 16'h3FFF) : (ang & 16'h3FFF);
      rem = ph & 16'h3F;
      idx = (ph >> 6) <= 128 ? (ph >> 6) : 128;
      c = TRIG_C[idx];
      s = TRIG_S[idx];
      for (int i = 0; i < 9; i++)
         if (ph > COS_STEPS[i]) c = c + rem;
      s = s + rem * 4;
      if (ph <= 8057) begin
         s = s + rem;
         if (ph <= 5263) s = s + rem;
      end
      cv = (c >> 2) + COS_BIAS;
      sv = -(s >> 1);
      if (flag[13]) begin
         tmp = cv; cv = sv; sv = tmp;
      end
      if (!flag[14]) cv = negate_clip(cv);
      if (!flag[15]) sv = negate_clip(sv);
      o.angle = ang;
      o.cosine = cv;
      o.sine = sv;
      return o;
   endfunction

   assign pending = expected_rsps.size();

   always @(posedge clock) begin
      vad_rsp_type want;
      if (reset) begin
         fail_count <= 0;
         rsp_count <= 0;
      end else begin
         if (start && !busy) expected_rsps.push_back(predict_direction(req));
         if (rsp_valid) begin
            rsp_count <= rsp_count + 1;
            if (expected_rsps.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %h", rsp);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp.zero_vector !== want.zero_vector || rsp.angle !== want.angle ||
                   rsp.cosine !== want.cosine || rsp.sine !== want.sine) begin
                  if (fail_count < 10)
                     $display("mismatch: exp a=%h c=%h s=%h z=%b got a=%h c=%h s=%h z=%b",
                        want.angle, want.cosine, want.sine, want.zero_vector,
                        rsp.angle, rsp.cosine, rsp.sine, rsp.zero_vector);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

@@ verif/testbench.sv @@
module testbench;
   import vad_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   vad_req_type req = '0;
   logic        rsp_valid;
   vad_rsp_type rsp;
   int          fail_count, pending, rsp_count;
   int          cycles = 0;
   int          sent = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   vector_angle_and_direction_top dut (.clock, .reset, .start, .busy, .req, .rsp_valid, .rsp);
   vad_checker checker_i (.clock, .reset, .start, .busy, .req, .rsp_valid, .rsp,
      .fail_count, .pending, .rsp_count);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 200000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // hold one vector until the transaction is taken
   task automatic send_vector(logic [15:0] x, logic [15:0] y, bit may_idle);
      while (may_idle && $urandom_range(99) < 13) begin
         start <= 0;
         @(negedge clock);
      end
      req.dx <= x;
      req.dy <= y;
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'($urandom_range(8)) - 16'd4;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] a, b;
      repeat (2) @(negedge clock);
      reset <= 0;
      send_vector(16'h0000, 16'h0000, 0);
      send_vector(16'h7FFF, 16'h0000, 0);
      send_vector(16'h0000, 16'h7FFF, 0);
      send_vector(16'h8001, 16'h0000, 0);
      send_vector(16'h0000, 16'h8001, 0);
      send_vector(16'h8000, 16'h0005, 0);
      send_vector(16'h0005, 16'h8000, 0);
      send_vector(16'h8000, 16'h8000, 0);
      send_vector(16'h7FFF, 16'h7FFF, 0);
      send_vector(16'h7FFF, 16'h8001, 0);  // diagonal, quotient -32768
      send_vector(16'h8001, 16'h7FFF, 0);
      send_vector(16'h8001, 16'h8001, 0);
      send_vector(16'h0064, 16'hFF9C, 0);
      send_vector(16'h0001, 16'h0001, 0);
      send_vector(16'hFFFF, 16'h0000, 0);
      send_vector(16'h7FFF, 16'h7FFE, 0);
      send_vector(16'h7FFF, 16'h0001, 0);
      send_vector(16'h4000, 16'h1000, 0);
      start <= 0;
      // pause until the pipeline drains
      while (pending != 0) @(negedge clock);
      for (int i = 0; i < 2000; i++) begin
         if ($urandom_range(3) == 0) begin
            a = pick_value();
            b = pick_value();
         end else begin
            a = 16'($urandom);
            b = 16'($urandom);
         end
         send_vector(a, b, !(i >= 800 && i < 1100));
      end
      start <= 0;
      while (pending != 0) @(negedge clock);
      repeat (RSP_LATENCY + 5) @(negedge clock);
      $display("Covered %0d vectors (%0d results): axes, diagonals, -32768 inputs, zero vector.",
         sent, rsp_count);
      if (fail_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

@@ files.f @@
+incdir+hdl
hdl/vad_pkg.sv
hdl/vad_div.sv
hdl/vad_trig.sv
hdl/vector_angle_and_direction_top.sv
verif/vad_checker.sv
verif/testbench.sv
